// ===== sv/brb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the byte ring buffer with rewind
// Operation codes and stream field widths.
// ----------------------------------------------------------------------------
package brb_pkg;

	typedef enum logic [2:0] {
		OP_PUT    = 3'd0,
		OP_GET    = 3'd1,
		OP_RWD_RD = 3'd2,
		OP_RWD_WR = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned IN_W    = 24;
	localparam int unsigned OUT_W   = 24;

endpackage
`default_nettype wire

// ===== sv/byte_ring_buffer_with_rewind.sv =====
// Pipeline: an accepted item passes the store's registered read and then the
// output register before its result reaches the master side; one item per
// cycle sustained while the output is taken.
// Reset: asynchronous, active low; pointers and count go to zero, then a
// clearing pass writes zero to every store entry, during which no item is
// accepted.
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_rewind: circular byte store with overwrite and rewind
// Put, get, rewind read, rewind write and clear, one operation per item,
// one result per item carrying the read byte, fill count and flags.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_rewind #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// [2:0] op, [10:3] data_byte, [18:11] rewind_amount, [23:19] zero
	input  wire logic [brb_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// [7:0] read_byte, [14:8] available_count, [15] was_empty,
	// [16] overwrote_oldest, [23:17] zero
	output logic      [brb_pkg::OUT_W-1:0] m_axis_tdata
);

	import brb_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = ((CW > BYTE_W) ? CW : BYTE_W) + 1;

	// ring position helpers, p below DEPTH, k at most DEPTH
	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
		logic [CW-1:0] t;
		t = CW'(p) + CW'(1);
		return (t == CW'(DEPTH)) ? PW'(0) : t[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p,
		input logic [CW-1:0] k);
		logic [CW:0] t;
		if (CW'(p) >= k) begin
			t = (CW+1)'(p) - (CW+1)'(k);
		end else begin
			t = (CW+1)'(p) + (CW+1)'(DEPTH) - (CW+1)'(k);
		end
		return t[PW-1:0];
	endfunction

	logic [PW-1:0] rp_q, wp_q, clr_cnt_q;
	logic [CW-1:0] cnt_q;
	logic          clearing_q;

	logic [PW-1:0] rp_n, wp_n;
	logic [CW-1:0] cnt_n;
	logic          empty_n, over_n;

	op_t                op;
	logic [BYTE_W-1:0]  data_byte;
	logic [BYTE_W-1:0]  rewind_amount;
	logic               accept;
	logic               move_s1;

	logic [SW-1:0]      sum;
	logic [CW-1:0]      target;
	logic [CW-1:0]      back;
	logic [CW+COUNT_W-1:0] cnt_ext;

	logic               vld_s1, get_s1, empty_s1, over_s1;
	logic [COUNT_W-1:0] cnt_s1;
	logic [BYTE_W-1:0]  rdata;
	logic               out_vld_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               ram_we;
	logic [PW-1:0]      ram_waddr;
	logic [BYTE_W-1:0]  ram_wdata;

	assign op            = op_t'(s_axis_tdata[2:0]);
	assign data_byte     = s_axis_tdata[10:3];
	assign rewind_amount = s_axis_tdata[18:11];

	assign move_s1       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!vld_s1 || move_s1);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		rp_n    = rp_q;
		wp_n    = wp_q;
		cnt_n   = cnt_q;
		empty_n = 1'b0;
		over_n  = 1'b0;
		sum     = SW'(cnt_q) + SW'(rewind_amount);
		target  = '0;
		back    = '0;
		unique case (op)
			OP_PUT: begin
				wp_n = ring_inc(wp_q);
				if (cnt_q < CW'(DEPTH)) begin
					cnt_n = cnt_q + CW'(1);
				end else begin
					over_n = 1'b1;
					rp_n   = ring_inc(wp_q);
				end
			end
			OP_GET: begin
				if (cnt_q != '0) begin
					rp_n  = ring_inc(rp_q);
					cnt_n = cnt_q - CW'(1);
				end else begin
					empty_n = 1'b1;
				end
			end
			OP_RWD_RD: begin
				target = (sum >= SW'(DEPTH - 1)) ? CW'(DEPTH - 1) : sum[CW-1:0];
				// a full store drops its oldest byte
				if (cnt_q == CW'(DEPTH)) begin
					rp_n = ring_inc(rp_q);
				end else begin
					rp_n = ring_dec(rp_q, target - cnt_q);
				end
				cnt_n = target;
			end
			OP_RWD_WR: begin
				target = (SW'(cnt_q) > SW'(rewind_amount)) ?
					(cnt_q - CW'(rewind_amount)) : CW'(0);
				back   = cnt_q - target;
				if (back == CW'(DEPTH)) begin
					back = '0;
				end
				wp_n  = ring_dec(wp_q, back);
				cnt_n = target;
			end
			OP_CLEAR: begin
				rp_n  = '0;
				wp_n  = '0;
				cnt_n = '0;
			end
			default: begin
			end
		endcase
	end

	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			wp_q       <= '0;
			cnt_q      <= '0;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == PW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + PW'(1);
				end
			end
			if (accept) begin
				rp_q  <= rp_n;
				wp_q  <= wp_n;
				cnt_q <= cnt_n;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = accept && (op == OP_PUT);
			ram_waddr = wp_q;
			ram_wdata = data_byte;
		end
	end

	brb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(rp_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (move_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			get_s1   <= (op == OP_GET);
			empty_s1 <= empty_n;
			over_s1  <= over_n;
			cnt_s1   <= cnt_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q <= {7'd0, over_s1, empty_s1, cnt_s1,
				get_s1 ? rdata : BYTE_W'(0)};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== sv/brb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module brb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the byte ring buffer with rewind
// Streams put, get, rewind and clear items into the block under random
// stalls on both sides. Each result is checked against a ring model.
// ----------------------------------------------------------------------------
module tb_top;
	import brb_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int          PTR_W       = $clog2(DEPTH);
	localparam int          CLK_HALF    = 6;
	localparam int          RAND_ITEMS  = 1000;
	localparam int          IDLE_PCT    = 38;
	localparam int          CALM_LO     = 400;
	localparam int          CALM_HI     = 900;
	localparam int          DRAIN_AT    = 600;
	localparam int          TAIL_CYCLES = 10;
	localparam int          MAX_PRINT   = 40;
	localparam longint      LIMIT_NS    = 200000 * 2 * CLK_HALF;

	// op codes the block does not decode
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	// highest bits first, as on m_axis_tdata
	typedef struct packed {
		logic               over;
		logic               empty;
		logic [COUNT_W-1:0] count;
		logic [BYTE_W-1:0]  read_byte;
	} ring_result_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	// ring model state
	logic [BYTE_W-1:0] ring_mem [DEPTH];
	logic [PTR_W-1:0]  rd_ptr;
	logic [PTR_W-1:0]  wr_ptr;
	int                fill;

	logic [IN_W-1:0]   stim_items [$];
	ring_result_t      expected_results [$];

	int presented_count = 0;
	int accepted_count  = 0;
	int result_count    = 0;
	int cycle_count     = 0;
	int directed_count  = 0;
	int error_count     = 0;
	int op_seen [8]     = '{default: 0};
	int n_overwrite     = 0;
	int n_empty_get     = 0;
	int n_full_rewind   = 0;

	byte_ring_buffer_with_rewind #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [IN_W-1:0] make_item(logic [2:0] op, logic [7:0] data,
			logic [7:0] amt);
		return {5'b0, amt, data, op};
	endfunction

	// bias toward the clamp points of both rewinds
	function automatic logic [7:0] rand_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 8'($urandom_range(0, 3));
		else if (r < 50)
			return 8'($urandom_range(60, 70));
		else if (r < 60)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p, int delta);
		return PTR_W'((int'(p) + delta + int'(DEPTH)) % int'(DEPTH));
	endfunction

	// apply one op to the ring model and return the result it gives
	function automatic ring_result_t apply_ring_op(logic [2:0] op, logic [7:0] data,
			logic [7:0] amt);
		ring_result_t r;
		int           a;
		int           target;
		r = '0;
		a = int'(amt);
		op_seen[op]++;
		case (op)
			OP_PUT: begin
				ring_mem[wr_ptr] = data;
				wr_ptr = ring_step(wr_ptr, 1);
				if (fill < DEPTH) begin
					fill++;
				end else begin
					// full: drop the oldest byte
					r.over = 1'b1;
					rd_ptr = wr_ptr;
					n_overwrite++;
				end
			end
			OP_GET: begin
				r.read_byte = ring_mem[rd_ptr];
				if (fill != 0) begin
					rd_ptr = ring_step(rd_ptr, 1);
					fill--;
				end else begin
					r.empty = 1'b1;
					n_empty_get++;
				end
			end
			OP_RWD_RD: begin
				target = fill + a;
				if (target >= DEPTH)
					target = DEPTH - 1;
				if (fill == DEPTH)
					n_full_rewind++;
				// from a full store this moves the pointer forward by one
				rd_ptr = ring_step(rd_ptr, fill - target);
				fill = target;
			end
			OP_RWD_WR: begin
				target = (fill > a) ? fill - a : 0;
				wr_ptr = ring_step(wr_ptr, target - fill);
				fill = target;
			end
			OP_CLEAR: begin
				rd_ptr = '0;
				wr_ptr = '0;
				fill = 0;
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(fill);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < MAX_PRINT)
			$display("MISMATCH result %0d %s: got %0d, want %0d", result_count, what, got,
				want);
		error_count++;
	endtask

	// check results and record accepted items
	always @(posedge clk) begin : monitor
		ring_result_t got;
		ring_result_t want;
		if (arst_n) begin
			cycle_count++;
			if (m_axis_tvalid && m_axis_tready) begin
				got = ring_result_t'(m_axis_tdata[$bits(ring_result_t)-1:0]);
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", int'(m_axis_tdata), -1);
				end else begin
					want = expected_results.pop_front();
					if (got.read_byte !== want.read_byte)
						report_mismatch("read_byte", got.read_byte, want.read_byte);
					if (got.count !== want.count)
						report_mismatch("available_count", got.count, want.count);
					if (got.empty !== want.empty)
						report_mismatch("was_empty", got.empty, want.empty);
					if (got.over !== want.over)
						report_mismatch("overwrote_oldest", got.over, want.over);
				end
				result_count++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(apply_ring_op(s_axis_tdata[2:0],
					s_axis_tdata[10:3], s_axis_tdata[18:11]));
				accepted_count++;
			end
		end
	end

	always @(negedge clk) begin : driver
		logic calm;
		logic hold;
		logic idle;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			calm = (cycle_count >= CALM_LO) && (cycle_count < CALM_HI);
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			// advance only once the current item has been taken
			if (accepted_count == presented_count) begin
				hold = (presented_count == DRAIN_AT || presented_count == directed_count) &&
					(expected_results.size() != 0);
				idle = !calm && ($urandom_range(0, 99) < IDLE_PCT);
				if (!hold && !idle && stim_items.size() != 0) begin
					s_axis_tdata  <= stim_items.pop_front();
					s_axis_tvalid <= 1'b1;
					presented_count++;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	initial begin : stimulus
		int len;
		int mode;
		int r;
		logic [2:0] op;

		foreach (ring_mem[i])
			ring_mem[i] = '0;
		rd_ptr = '0;
		wr_ptr = '0;
		fill   = 0;

		// directed: field extremes, every op, clamps, empty store, spare codes
		stim_items.push_back(make_item(OP_GET, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_PUT, 8'h00, 8'hFF));
		stim_items.push_back(make_item(OP_PUT, 8'hFF, 8'h00));
		stim_items.push_back(make_item(OP_PUT, 8'h55, 8'hAA));
		stim_items.push_back(make_item(OP_GET, 8'hFF, 8'hFF));
		stim_items.push_back(make_item(OP_RWD_RD, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_RWD_RD, 8'h00, 8'hFF));
		stim_items.push_back(make_item(OP_GET, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_RWD_WR, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_RWD_WR, 8'h00, 8'hFF));
		stim_items.push_back(make_item(OP_GET, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_PUT, 8'hAA, 8'h55));
		stim_items.push_back(make_item(OP_RWD_RD, 8'h00, 8'h01));
		stim_items.push_back(make_item(OP_RWD_WR, 8'h00, 8'h01));
		stim_items.push_back(make_item(OP_CLEAR, 8'hFF, 8'hFF));
		stim_items.push_back(make_item(OP_GET, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_RSVD_5, 8'hFF, 8'hFF));
		stim_items.push_back(make_item(OP_RSVD_6, 8'h12, 8'h34));
		stim_items.push_back(make_item(OP_RSVD_7, 8'h00, 8'h00));
		stim_items.push_back(make_item(OP_PUT, 8'h81, 8'h00));
		stim_items.push_back(make_item(OP_RWD_WR, 8'h00, 8'h80));
		stim_items.push_back(make_item(OP_RWD_RD, 8'h00, 8'h40));
		stim_items.push_back(make_item(OP_CLEAR, 8'h00, 8'h00));
		directed_count = stim_items.size();

		// random: bursts that fill, drain and rewind the ring, mixed with short random runs
		while (stim_items.size() - directed_count < RAND_ITEMS) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1: begin
					len = $urandom_range(1, 80);
					repeat (len)
						stim_items.push_back(make_item(OP_PUT, 8'($urandom_range(0, 255)),
							rand_amount()));
				end
				2: begin
					len = $urandom_range(1, 70);
					repeat (len)
						stim_items.push_back(make_item(OP_GET, 8'($urandom_range(0, 255)),
							rand_amount()));
				end
				3: begin
					// overflow the ring, then rewind the read side from full
					len = $urandom_range(DEPTH, DEPTH + 26);
					repeat (len)
						stim_items.push_back(make_item(OP_PUT, 8'($urandom_range(0, 255)),
							rand_amount()));
					stim_items.push_back(make_item(OP_RWD_RD, 8'($urandom_range(0, 255)),
						rand_amount()));
					len = $urandom_range(1, 10);
					repeat (len)
						stim_items.push_back(make_item(OP_GET, 8'($urandom_range(0, 255)),
							rand_amount()));
				end
				4: begin
					stim_items.push_back(make_item(OP_RWD_WR, 8'($urandom_range(0, 255)),
						rand_amount()));
					len = $urandom_range(1, 12);
					repeat (len)
						stim_items.push_back(make_item(OP_PUT, 8'($urandom_range(0, 255)),
							rand_amount()));
				end
				default: begin
					len = $urandom_range(4, 16);
					repeat (len) begin
						r = $urandom_range(0, 99);
						if (r < 35)
							op = OP_PUT;
						else if (r < 65)
							op = OP_GET;
						else if (r < 78)
							op = OP_RWD_RD;
						else if (r < 91)
							op = OP_RWD_WR;
						else if (r < 97)
							op = OP_CLEAR;
						else
							op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
						stim_items.push_back(make_item(op, 8'($urandom_range(0, 255)),
							rand_amount()));
					end
				end
			endcase
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || accepted_count != presented_count ||
				expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		while (expected_results.size() != 0) begin
			void'(expected_results.pop_front());
			report_mismatch("missing result", -1, 0);
		end

		$display("Checked %0d results: %0d put, %0d get, %0d rewind read, %0d rewind write,",
			result_count, op_seen[OP_PUT], op_seen[OP_GET], op_seen[OP_RWD_RD],
			op_seen[OP_RWD_WR]);
		$display("%0d clear, %0d spare op; %0d overwrites, %0d empty gets, %0d full rewinds",
			op_seen[OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7], n_overwrite,
			n_empty_get, n_full_rewind);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
